// ===== rtl/core/vsfr_pkg.sv =====
// Shared constants and types for the vehicle status frame receiver.
// Used by vsfr_parser, vsfr_decode, the top level and the checker.
package vsfr_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR_S  = 8'h53;
  localparam logic [7:0] HDR_T  = 8'h54;
  localparam logic [7:0] HDR_X  = 8'h58;
  localparam logic [7:0] TRL_CR = 8'h0D;
  localparam logic [7:0] TRL_LF = 8'h0A;

  localparam int PAY_LEN = 13;
  localparam int POS_W   = 5;

  // Frame position codes
  localparam logic [POS_W-1:0] POS_HUNT = 5'd0;
  localparam logic [POS_W-1:0] POS_T    = 5'd1;
  localparam logic [POS_W-1:0] POS_X    = 5'd2;
  localparam logic [POS_W-1:0] POS_PAY0 = 5'd3;
  localparam logic [POS_W-1:0] POS_PAYL = 5'd15;
  localparam logic [POS_W-1:0] POS_CR   = 5'd16;
  localparam logic [POS_W-1:0] POS_LF   = 5'd17;

  // Gear codes
  localparam logic [1:0] GEAR_FWD = 2'd0;
  localparam logic [1:0] GEAR_NEU = 2'd1;
  localparam logic [1:0] GEAR_BWD = 2'd2;

  // Payload bytes, entry 0 is the first payload byte of the frame
  typedef logic [PAY_LEN-1:0][7:0] payload_t;

  // Parser status toward the top level and the decoder
  typedef struct packed {
    logic done;    // accepted byte closes a good frame
    logic at_lf;   // next byte may close a frame
  } vsfr_ctrl_t;

endpackage

// ===== rtl/core/vsfr_parser.sv =====
// Frame position tracker and payload capture shift line.
// Depends on vsfr_pkg.
module vsfr_parser
  import vsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output payload_t   payload,
  output vsfr_ctrl_t ctrl
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;

  // Next position for the accepted byte
  always_comb begin
    case (pos)
      POS_HUNT: pos_next = (rx_byte == HDR_S) ? POS_T : POS_HUNT;
      POS_T:    pos_next = (rx_byte == HDR_T) ? POS_X : POS_HUNT;
      POS_X:    pos_next = (rx_byte == HDR_X) ? POS_PAY0 : POS_HUNT;
      POS_CR:   pos_next = (rx_byte == TRL_CR) ? POS_LF : POS_HUNT;
      POS_LF:   pos_next = POS_HUNT;
      default: begin
        if (pos >= POS_PAY0 && pos <= POS_PAYL) begin
          pos_next = pos + 5'd1;
        end else begin
          // unreachable codes behave like hunting
          pos_next = (rx_byte == HDR_S) ? POS_T : POS_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Payload shifts down; after 13 bytes entry 0 holds payload byte 0
  always_ff @(posedge clk) begin
    if (accept && pos >= POS_PAY0 && pos <= POS_PAYL) begin
      payload <= {rx_byte, payload[PAY_LEN-1:1]};
    end
  end

  assign ctrl.at_lf = (pos == POS_LF);
  assign ctrl.done  = accept && (pos == POS_LF) && (rx_byte == TRL_LF);

endmodule

// ===== rtl/core/vsfr_decode.sv =====
// Status decode and output register with valid/stall handshake.
// Depends on vsfr_pkg.
module vsfr_decode
  import vsfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  payload_t           payload,
  input  vsfr_ctrl_t         ctrl,
  output logic               status_valid,
  input  logic               status_stall,
  output logic               mode_auto,
  output logic               estop_on,
  output logic [1:0]         gear_state,
  output logic [15:0]        speed_value,
  output logic signed [15:0] steer_value,
  output logic [7:0]         brake_value,
  output logic signed [31:0] encoder_count,
  output logic [7:0]         alive_count
);

  logic [1:0] gear_next;

  // Gear mapping from payload byte 2
  always_comb begin
    case (payload[2])
      8'd0:    gear_next = GEAR_FWD;
      8'd1:    gear_next = GEAR_NEU;
      default: gear_next = GEAR_BWD;
    endcase
  end

  // Valid flag: set on a completed frame, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (ctrl.done) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      mode_auto     <= |payload[0];
      estop_on      <= |payload[1];
      gear_state    <= gear_next;
      speed_value   <= {payload[4], payload[3]};
      steer_value   <= {payload[6], payload[5]};
      brake_value   <= payload[7];
      encoder_count <= {payload[11], payload[10], payload[9], payload[8]};
      alive_count   <= payload[12];
    end
  end

endmodule

// ===== rtl/core/vehicle_status_frame_receiver.sv =====
// Status is registered: it is valid in the cycle after the closing 0x0A byte is accepted.
// Throughput: one byte per cycle; a byte is held off only when it could close
// a frame while the previous status is still stalled in the output register.
// Reset (rst, synchronous): position returns to header hunt, no status valid;
// the payload bytes are not reset. Depends on vsfr_pkg, vsfr_parser, vsfr_decode.
module vehicle_status_frame_receiver
  import vsfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               status_valid,
  input  logic               status_stall,
  output logic               mode_auto,
  output logic               estop_on,
  output logic [1:0]         gear_state,
  output logic [15:0]        speed_value,
  output logic signed [15:0] steer_value,
  output logic [7:0]         brake_value,
  output logic signed [31:0] encoder_count,
  output logic [7:0]         alive_count
);

  payload_t   payload;
  vsfr_ctrl_t ctrl;
  logic       accept;

  // Only the frame-closing byte waits for the output register
  assign rx_stall = status_valid && status_stall && ctrl.at_lf;
  assign accept   = rx_valid && !rx_stall;

  vsfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .payload (payload),
    .ctrl    (ctrl)
  );

  vsfr_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .payload       (payload),
    .ctrl          (ctrl),
    .status_valid  (status_valid),
    .status_stall  (status_stall),
    .mode_auto     (mode_auto),
    .estop_on      (estop_on),
    .gear_state    (gear_state),
    .speed_value   (speed_value),
    .steer_value   (steer_value),
    .brake_value   (brake_value),
    .encoder_count (encoder_count),
    .alive_count   (alive_count)
  );

endmodule

// ===== rtl/core/vsfr_checker.sv =====
// Port-level checks for vehicle_status_frame_receiver, bound to the top level.
// Depends on vsfr_pkg.
module vsfr_checker
  import vsfr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               rx_valid,
  input logic               rx_stall,
  input logic [7:0]         rx_byte,
  input logic               status_valid,
  input logic               status_stall,
  input logic               mode_auto,
  input logic               estop_on,
  input logic [1:0]         gear_state,
  input logic [15:0]        speed_value,
  input logic signed [15:0] steer_value,
  input logic [7:0]         brake_value,
  input logic signed [31:0] encoder_count,
  input logic [7:0]         alive_count
);

  // A stalled status request stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_stall |=> status_valid)
    else $error("status request dropped while stalled");

  // A stalled status request keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_stall |=> $stable(mode_auto) && $stable(estop_on)
      && $stable(gear_state) && $stable(speed_value) && $stable(steer_value)
      && $stable(brake_value) && $stable(encoder_count) && $stable(alive_count))
    else $error("status payload changed while stalled");

  // A new status only follows an accepted line feed
  a_rise_after_lf: assert property (@(posedge clk) disable iff (rst)
    $rose(status_valid) |-> $past(rx_valid && !rx_stall && rx_byte == TRL_LF))
    else $error("status without closing line feed");

  // Input is held off only behind a stalled status
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> status_valid && status_stall)
    else $error("input stalled without output backpressure");

  // A valid status never carries the unused gear code
  a_gear_code: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> gear_state != 2'd3)
    else $error("invalid gear code");

endmodule

bind vehicle_status_frame_receiver vsfr_checker u_vsfr_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for vehicle_status_frame_receiver: feeds serial bytes
// (good, broken and noise frames), predicts the decoded status of each frame.
// Depends on vsfr_pkg and the receiver RTL.
module tb_top;
  import vsfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               mode_auto;
    logic               estop_on;
    logic [1:0]         gear_state;
    logic [15:0]        speed_value;
    logic signed [15:0] steer_value;
    logic [7:0]         brake_value;
    logic signed [31:0] encoder_count;
    logic [7:0]         alive_count;
  } vehicle_status_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               status_valid;
  logic               status_stall = 1'b0;
  logic               mode_auto;
  logic               estop_on;
  logic [1:0]         gear_state;
  logic [15:0]        speed_value;
  logic signed [15:0] steer_value;
  logic [7:0]         brake_value;
  logic signed [31:0] encoder_count;
  logic [7:0]         alive_count;

  // Bytes waiting to be sent and statuses waiting to come out
  logic [7:0]      rx_bytes_q[$];
  vehicle_status_t expected_status_q[$];

  // Predictor state
  logic [POS_W-1:0] frame_pos = POS_HUNT;
  payload_t         payload_store = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;

  vehicle_status_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .mode_auto    (mode_auto),
    .estop_on     (estop_on),
    .gear_state   (gear_state),
    .speed_value  (speed_value),
    .steer_value  (steer_value),
    .brake_value  (brake_value),
    .encoder_count(encoder_count),
    .alive_count  (alive_count)
  );

  always #5 clk = ~clk;

  function automatic string fmt_status(input vehicle_status_t s);
    return $sformatf("auto=%0d estop=%0d gear=%0d speed=%0d steer=%0d brake=%0d enc=%0d alive=%0d",
                     s.mode_auto, s.estop_on, s.gear_state, s.speed_value, s.steer_value,
                     s.brake_value, s.encoder_count, s.alive_count);
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ERROR %s", $realtime, msg);
  endtask

  // Frame parser: advance one byte, queue the decoded status on a closing LF
  task automatic parse_byte(input logic [7:0] b);
    vehicle_status_t st;
    logic [POS_W-1:0] pos;
    pos = frame_pos;
    if (pos > POS_LF) pos = POS_HUNT;
    if (pos == POS_HUNT) begin
      frame_pos = (b == HDR_S) ? POS_T : POS_HUNT;
    end else if (pos == POS_T) begin
      frame_pos = (b == HDR_T) ? POS_X : POS_HUNT;
    end else if (pos == POS_X) begin
      frame_pos = (b == HDR_X) ? POS_PAY0 : POS_HUNT;
    end else if (pos <= POS_PAYL) begin
      payload_store[4'(pos - POS_PAY0)] = b;
      frame_pos = pos + 1'b1;
    end else if (pos == POS_CR) begin
      frame_pos = (b == TRL_CR) ? POS_LF : POS_HUNT;
    end else begin
      frame_pos = POS_HUNT;
      if (b == TRL_LF) begin
        st.mode_auto     = (payload_store[0] != 8'h00);
        st.estop_on      = (payload_store[1] != 8'h00);
        st.gear_state    = (payload_store[2] == 8'd0) ? GEAR_FWD :
                           (payload_store[2] == 8'd1) ? GEAR_NEU : GEAR_BWD;
        st.speed_value   = {payload_store[4], payload_store[3]};
        st.steer_value   = {payload_store[6], payload_store[5]};
        st.brake_value   = payload_store[7];
        st.encoder_count = {payload_store[11], payload_store[10],
                            payload_store[9], payload_store[8]};
        st.alive_count   = payload_store[12];
        expected_status_q.push_back(st);
      end
    end
  endtask

  // Compare one accepted status with the oldest prediction
  task automatic check_status();
    vehicle_status_t got;
    vehicle_status_t want;
    got = '{mode_auto, estop_on, gear_state, speed_value, steer_value,
            brake_value, encoder_count, alive_count};
    if (expected_status_q.size() == 0) begin
      note_error({"status with no frame pending: ", fmt_status(got)});
    end else begin
      want = expected_status_q.pop_front();
      if (got.mode_auto !== want.mode_auto || got.estop_on !== want.estop_on ||
          got.gear_state !== want.gear_state || got.speed_value !== want.speed_value ||
          got.steer_value !== want.steer_value || got.brake_value !== want.brake_value ||
          got.encoder_count !== want.encoder_count ||
          got.alive_count !== want.alive_count)
        note_error({"status mismatch\n  exp: ", fmt_status(want),
                    "\n  got: ", fmt_status(got)});
    end
  endtask

  // Queue a frame; when cut_at hits a position, that byte is replaced by junk
  // and the frame stops there
  task automatic queue_frame(input payload_t pay, input int cut_at, input logic [7:0] junk);
    logic [7:0] frame_bytes [18];
    frame_bytes[0]  = HDR_S;
    frame_bytes[1]  = HDR_T;
    frame_bytes[2]  = HDR_X;
    for (int i = 0; i < PAY_LEN; i++) frame_bytes[3 + i] = pay[i];
    frame_bytes[16] = TRL_CR;
    frame_bytes[17] = TRL_LF;
    for (int i = 0; i < 18; i++) begin
      if (i == cut_at) begin
        rx_bytes_q.push_back(junk);
        break;
      end
      rx_bytes_q.push_back(frame_bytes[i]);
    end
  endtask

  function automatic logic [7:0] special_byte();
    case ($urandom_range(4))
      0: return HDR_S;
      1: return TRL_CR;
      2: return TRL_LF;
      3: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // Random payload, biased toward delimiter values and each gear code
  function automatic payload_t rand_payload();
    payload_t p;
    for (int i = 0; i < PAY_LEN; i++)
      p[i] = ($urandom_range(9) == 0) ? special_byte() : 8'($urandom);
    if ($urandom_range(3) != 3) p[2] = 8'($urandom_range(2));
    return p;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || !rx_stall) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte  <= rx_bytes_q.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Status backpressure
  always @(posedge clk) begin
    status_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check outgoing status, then predict from the accepted byte
  always @(posedge clk) begin
    if (!rst) begin
      if (status_valid && !status_stall) check_status();
      if (rx_valid && !rx_stall) parse_byte(rx_byte);
    end
  end

  // Stimulus and end of test
  initial begin
    payload_t pay;
    int       queued;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      if (ph == 0) begin
        // All-zero and all-ones payloads
        queue_frame('0, -1, 8'h00);
        queue_frame('1, -1, 8'h00);
        // A second 'S' fails the T check and is not reused as a header start
        rx_bytes_q.push_back(HDR_S);
        rx_bytes_q.push_back(HDR_S);
        rx_bytes_q.push_back(HDR_T);
        rx_bytes_q.push_back(HDR_X);
        // Delimiters inside the payload, neutral gear, most negative values
        pay = '0;
        pay[1]  = TRL_CR;
        pay[2]  = 8'd1;
        pay[6]  = 8'h80;
        pay[7]  = TRL_LF;
        pay[11] = 8'h80;
        pay[12] = HDR_S;
        queue_frame(pay, -1, 8'h00);
        // LF where CR belongs: no status
        queue_frame(pay, 16, TRL_LF);
      end

      queued = 0;
      while (queued < 225) begin
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
          queue_frame(rand_payload(), -1, 8'h00);
          queued += 18;
        end else if (r < 85) begin
          int cut;
          cut = $urandom_range(17);
          queue_frame(rand_payload(), cut,
                      ($urandom_range(3) == 0) ? HDR_S : 8'($urandom));
          queued += cut + 1;
        end else begin
          int n;
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
              0: rx_bytes_q.push_back(HDR_S);
              1: rx_bytes_q.push_back(HDR_T);
              2: rx_bytes_q.push_back(HDR_X);
              default: rx_bytes_q.push_back(8'($urandom));
            endcase
          end
          queued += n;
        end
      end

      // Drain, sampled away from the rising edge so all updates have settled
      while (rx_bytes_q.size() != 0 || rx_valid || expected_status_q.size() != 0)
        @(negedge clk);
    end

    repeat (10) @(posedge clk);
    if (expected_status_q.size() != 0)
      note_error($sformatf("%0d statuses never arrived", expected_status_q.size()));
    if (err_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
